// ----- design/i2p_pkg.sv -----
// Package for the infix-to-postfix converter.
// Holds request/response types, controller-datapath link types, and the
// character-class helpers. No dependencies.
package i2p_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PREC_W      = 3;

    localparam logic [0:0] KIND_CHAR = 1'b0;
    localparam logic [0:0] KIND_END  = 1'b1;

    localparam logic [7:0] CH_POW = 8'h5E;
    localparam logic [7:0] CH_MUL = 8'h2A;
    localparam logic [7:0] CH_DIV = 8'h2F;
    localparam logic [7:0] CH_ADD = 8'h2B;
    localparam logic [7:0] CH_SUB = 8'h2D;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic [PREC_W-1:0] PREC_POW   = 3'd4;
    localparam logic [PREC_W-1:0] PREC_MUL   = 3'd3;
    localparam logic [PREC_W-1:0] PREC_ADD   = 3'd2;
    localparam logic [PREC_W-1:0] PREC_OTHER = 3'd0;

    typedef struct packed {
        logic [0:0] kind;
        logic [7:0] symbol;
    } req_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
        logic       overflow;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic pop;
        logic emit_sym;
        logic emit_term;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic is_end;
        logic is_alnum;
        logic empty;
        logic top_ge;
        logic slot_free;
    } status_t;

    function automatic logic [PREC_W-1:0] prec_of(input logic [7:0] c);
        logic [PREC_W-1:0] p;
        case (c)
            CH_POW:          p = PREC_POW;
            CH_MUL, CH_DIV:  p = PREC_MUL;
            CH_ADD, CH_SUB:  p = PREC_ADD;
            default:         p = PREC_OTHER;
        endcase
        return p;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

// ----- design/infix_to_postfix_converter.sv -----
// Top level of the infix-to-postfix converter (operator precedence, no parentheses).
// Instantiates i2p_ctrl and i2p_dp; depends on i2p_pkg.
//
//  channel | handshake            | payload
//  request | req_valid/req_ready  | req  (kind, symbol)
//  response| rsp_valid/rsp_ready  | rsp  (out_char, last, overflow)
//
// One request at a time, taken while idle; its responses follow (letter/digit:
// itself; operator: pops, then a push; end: pops, then a terminator). Operator
// pops go one per cycle through the stack's top entry while a response slot is free.
// rst_n clears stack count, overflow flag and response valid; no clearing pass.
// A stalled response register holds the sequencer; an operator push needs no slot.
module infix_to_postfix_converter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  i2p_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output i2p_pkg::rsp_t  rsp
);
    import i2p_pkg::*;

    cmd_t    cmd;
    status_t status;

    i2p_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    i2p_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .rsp_ready (rsp_ready),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// ----- design/i2p_dp.sv -----
// Datapath: request latch, operator stack, overflow flag, response register.
// Depends on i2p_pkg.
module i2p_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  i2p_pkg::cmd_t    cmd,
    input  i2p_pkg::req_t    req,
    input  logic             rsp_ready,
    output i2p_pkg::status_t status,
    output logic             rsp_valid,
    output i2p_pkg::rsp_t    rsp
);
    import i2p_pkg::*;

    req_t             item_reg;
    logic [7:0]       stack_reg [STACK_DEPTH];
    logic [7:0]       top_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic [CNT_W-1:0] top_pos;
    logic [CNT_W-1:0] below_pos;
    logic [7:0]       top_sym;
    logic             full;

    // top_reg mirrors the entry at count_reg - 1 whenever the stack is not empty
    assign top_pos   = count_reg - CNT_W'(1);
    assign below_pos = count_reg - CNT_W'(2);
    assign top_sym   = top_reg;
    assign full      = (count_reg >= CNT_W'(STACK_DEPTH));

    always_comb
    begin
        status.is_end    = (item_reg.kind == KIND_END);
        status.is_alnum  = is_alnum(item_reg.symbol);
        status.empty     = (count_reg == '0);
        status.top_ge    = (prec_of(top_sym) >= prec_of(item_reg.symbol));
        status.slot_free = !rsp_valid_reg || rsp_ready;
    end

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        if (cmd.pop)
        begin
            count_next     = top_pos;
            rsp_valid_next = 1'b1;
            rsp_next       = '{out_char: top_sym, last: 1'b0, overflow: 1'b0};
        end
        if (cmd.emit_sym)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '{out_char: item_reg.symbol, last: 1'b0, overflow: 1'b0};
        end
        if (cmd.emit_term)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '{out_char: CH_NUL, last: 1'b1, overflow: ovf_reg};
            ovf_next       = 1'b0;
        end
        if (cmd.push)
        begin
            if (full)
                ovf_next = 1'b1;
            else
                count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (cmd.load)
            item_reg <= req;
        if (cmd.push && !full)
        begin
            stack_reg[count_reg[IDX_W-1:0]] <= item_reg.symbol;
            top_reg                         <= item_reg.symbol;
        end
        else if (cmd.pop)
            top_reg <= stack_reg[below_pos[IDX_W-1:0]];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> count_reg != '0)
        else $error("pop from empty stack");
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.pop, cmd.emit_sym, cmd.emit_term, cmd.push}))
        else $error("conflicting datapath commands");
    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_term |=> (count_reg == '0) && !ovf_reg && rsp_reg.last)
        else $error("terminator left state behind");
`endif

endmodule

// ----- design/i2p_ctrl.sv -----
// Controller FSM: takes one request, then sequences pops, emits and the push.
// Depends on i2p_pkg.
module i2p_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  i2p_pkg::status_t status,
    output i2p_pkg::cmd_t    cmd
);
    import i2p_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WORK = 1'b1;

    logic state_reg, state_next;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                if (status.is_end)
                begin
                    if (status.slot_free)
                    begin
                        if (!status.empty)
                            cmd.pop = 1'b1;
                        else
                        begin
                            cmd.emit_term = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                end
                else if (status.is_alnum)
                begin
                    if (status.slot_free)
                    begin
                        cmd.emit_sym = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else if (!status.empty && status.top_ge)
                begin
                    if (status.slot_free)
                        cmd.pop = 1'b1;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_load_then_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_WORK)
        else $error("load did not start work");
    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop || cmd.emit_sym || cmd.emit_term) |-> status.slot_free)
        else $error("emit into occupied response register");
    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sym || cmd.emit_term || cmd.push) |=> state_reg == ST_IDLE)
        else $error("finished request did not return to idle");
`endif

endmodule
